// ===== rtl/rtri_pkg.sv =====
// Shared types, constants and the distance tables of the RSSI trilateration block.
`timescale 1ns / 1ps
`default_nettype none

package rtri_pkg;

    localparam int ANCHOR_W    = 15;
    localparam int RSSI_W      = 8;
    localparam int POS_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int DIST_W      = 14;
    localparam int RSSI_STEPS  = 100;
    localparam int STEP_W      = 7;
    localparam int RSSI_FLOOR  = -99;
    localparam int EXP_FIRST   = 32;
    localparam int EXP_OTHER   = 37;

    localparam real INV_EXP_FIRST = 1.0 / EXP_FIRST;
    localparam real INV_EXP_OTHER = 1.0 / EXP_OTHER;

    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR1_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR1_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR2_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR2_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR3_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR3_Y = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEGEN = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

    typedef struct packed {
        logic signed [RSSI_W-1:0] rssi_first;
        logic signed [RSSI_W-1:0] rssi_second;
        logic signed [RSSI_W-1:0] rssi_third;
    } rtri_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [STATUS_W-1:0]     status;
    } rtri_out_t;

    typedef logic [RSSI_STEPS-1:0][DIST_W-1:0] dist_tab_t;

    // round(100 * 10^(s * inv_e - 1)) for attenuation step s, inv_e = 1 / e
    function automatic dist_tab_t build_dist_tab(input real inv_e);
        dist_tab_t t;
        real       v;
        t = '0;
        for (int s = 0; s < RSSI_STEPS; s++) begin
            v = 100.0 * (10.0 ** (real'(s) * inv_e - 1.0));
            t[s] = DIST_W'($rtoi(v + 0.5));
        end
        return t;
    endfunction

    localparam dist_tab_t DIST_FIRST = build_dist_tab(INV_EXP_FIRST);
    localparam dist_tab_t DIST_OTHER = build_dist_tab(INV_EXP_OTHER);

    function automatic logic [STEP_W-1:0] rssi_step(input logic signed [RSSI_W-1:0] r);
        logic [STEP_W-1:0] s;
        if (r > 0) begin
            s = '0;
        end
        else if (r < RSSI_FLOOR) begin
            s = STEP_W'(-RSSI_FLOOR);
        end
        else begin
            s = STEP_W'(-r);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rtri_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
`timescale 1ns / 1ps
`default_nettype none

module rtri_div
#(
    parameter int NW = 48,
    parameter int QW = 47,
    parameter int DW = 32,
    parameter int PW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [PW-1:0] side,
    output logic          out_valid,
    output logic [QW-1:0] quotient,
    output logic [PW-1:0] out_side
);

    logic          valid_reg [0:QW];
    logic [DW-1:0] rem_reg   [0:QW];
    logic [QW-1:0] qd_reg    [0:QW];
    logic [DW-1:0] dvs_reg   [0:QW];
    logic [PW-1:0] side_reg  [0:QW];

    logic [DW-1:0] rem_next  [0:QW-1];
    logic [QW-1:0] qd_next   [0:QW-1];

    always_comb
    begin
        for (int k = 0; k < QW; k++) begin
            logic [DW:0] trial;
            logic [DW:0] diff;
            logic        ge;
            trial       = {rem_reg[k], qd_reg[k][QW-1]};
            diff        = trial - {1'b0, dvs_reg[k]};
            ge          = trial >= {1'b0, dvs_reg[k]};
            rem_next[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
            qd_next[k]  = {qd_reg[k][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= QW; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            rem_reg[0]  <= DW'(dividend[NW-1:QW]);
            qd_reg[0]   <= dividend[QW-1:0];
            dvs_reg[0]  <= divisor;
            side_reg[0] <= side;
            for (int k = 1; k <= QW; k++) begin
                rem_reg[k]  <= rem_next[k-1];
                qd_reg[k]   <= qd_next[k-1];
                dvs_reg[k]  <= dvs_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign quotient  = qd_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

`default_nettype wire

// ===== rtl/rssi_trilateration.sv =====
// Top level of the RSSI trilateration pipeline.
// Accepts one request per cycle while the output is not stalled and returns one result per
// request, in order. The pipeline depth is set by the two pipelined dividers: 48 stages for
// the relative y and 17 for x, plus 13 stages of table lookup, multiplies, sums and
// saturation. A stalled result holds the whole pipeline. Anchor writes apply to every
// request accepted at or after the write edge; the block must be empty when anchors are
// written.
`timescale 1ns / 1ps
`default_nettype none

module rssi_trilateration
    import rtri_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  rtri_in_t             item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output rtri_out_t            result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ANCHOR_W-1:0]  cfg_data
);

    localparam int YNW = 48;
    localparam int YQW = 47;
    localparam int YDW = 32;
    localparam int YPW = 35;
    localparam int XNW = 32;
    localparam int XQW = 16;
    localparam int XDW = 16;
    localparam int XPW = 52;

    logic en;

    logic [ANCHOR_W-1:0] a1x_reg, a1y_reg, a2x_reg, a2y_reg, a3x_reg, a3y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a1x_reg <= '0;
            a1y_reg <= '0;
            a2x_reg <= '0;
            a2y_reg <= '0;
            a3x_reg <= '0;
            a3y_reg <= '0;
        end
        else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ANCHOR1_X: a1x_reg <= cfg_data;
                REG_ANCHOR1_Y: a1y_reg <= cfg_data;
                REG_ANCHOR2_X: a2x_reg <= cfg_data;
                REG_ANCHOR2_Y: a2y_reg <= cfg_data;
                REG_ANCHOR3_X: a3x_reg <= cfg_data;
                REG_ANCHOR3_Y: a3y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // anchor geometry, registered in a chain after a write: differences, products, denominator, flags
    logic signed [15:0] a_reg, b_reg, c_reg, d_reg;
    logic [ANCHOR_W-1:0] m_reg, n_reg;
    logic signed [31:0] aa_reg, bb_reg, cc_reg, dd_reg, bc_reg, da_reg, cm_reg;
    logic [15:0]        abs2c_reg;
    logic               c_neg_reg;
    logic signed [32:0] den_reg;
    logic               c_zero_reg;
    logic               degen_reg;
    logic               den_neg_reg;
    logic [YDW-1:0]     abs2den_reg;

    logic signed [15:0] c_abs;
    logic signed [32:0] den_abs;

    assign c_abs   = c_reg[15] ? -c_reg : c_reg;
    assign den_abs = den_reg[32] ? -den_reg : den_reg;

    always_ff @(posedge clk)
    begin
        a_reg       <= $signed({1'b0, a2x_reg}) - $signed({1'b0, a1x_reg});
        b_reg       <= $signed({1'b0, a2y_reg}) - $signed({1'b0, a1y_reg});
        c_reg       <= $signed({1'b0, a3x_reg}) - $signed({1'b0, a1x_reg});
        d_reg       <= $signed({1'b0, a3y_reg}) - $signed({1'b0, a1y_reg});
        m_reg       <= a1x_reg;
        n_reg       <= a1y_reg;
        aa_reg      <= a_reg * a_reg;
        bb_reg      <= b_reg * b_reg;
        cc_reg      <= c_reg * c_reg;
        dd_reg      <= d_reg * d_reg;
        bc_reg      <= b_reg * c_reg;
        da_reg      <= d_reg * a_reg;
        cm_reg      <= c_reg * $signed({1'b0, m_reg});
        abs2c_reg   <= {c_abs[14:0], 1'b0};
        c_neg_reg   <= c_reg[15];
        c_zero_reg  <= (c_reg == 16'sd0);
        den_reg     <= 33'(bc_reg) - 33'(da_reg);
        degen_reg   <= c_zero_reg || (den_reg == 33'sd0);
        den_neg_reg <= den_reg[32];
        abs2den_reg <= {den_abs[30:0], 1'b0};
    end

    assign en         = !(result_valid && result_stall);
    assign item_stall = !en;

    // front stages
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [DIST_W-1:0]  d1_reg, d2_reg, d3_reg;
    logic [27:0]        q1_reg, q2_reg, q3_reg;
    logic signed [28:0] d12_reg, d13_reg;
    logic signed [32:0] t1_reg, t2_reg, t2_p5_reg, t2_p6_reg, t2_p7_reg;
    logic signed [48:0] pm1_reg, pm2_reg, num_reg;
    logic [YNW-1:0]     ymag_reg;
    logic               sy_reg, degen_p7_reg;
    logic [YDW-1:0]     ydiv_reg;

    logic signed [48:0] num_abs;
    assign num_abs = num_reg[48] ? -num_reg : num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en) begin
            v1_reg <= item_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            d1_reg       <= DIST_FIRST[rssi_step(item.rssi_first)];
            d2_reg       <= DIST_OTHER[rssi_step(item.rssi_second)];
            d3_reg       <= DIST_OTHER[rssi_step(item.rssi_third)];
            q1_reg       <= d1_reg * d1_reg;
            q2_reg       <= d2_reg * d2_reg;
            q3_reg       <= d3_reg * d3_reg;
            d12_reg      <= $signed({1'b0, q1_reg}) - $signed({1'b0, q2_reg});
            d13_reg      <= $signed({1'b0, q1_reg}) - $signed({1'b0, q3_reg});
            t1_reg       <= 33'(d12_reg) + 33'(aa_reg) + 33'(bb_reg);
            t2_reg       <= 33'(d13_reg) + 33'(cc_reg) + 33'(dd_reg);
            pm1_reg      <= c_reg * t1_reg;
            pm2_reg      <= a_reg * t2_reg;
            t2_p5_reg    <= t2_reg;
            num_reg      <= pm1_reg - pm2_reg;
            t2_p6_reg    <= t2_p5_reg;
            ymag_reg     <= num_abs[YNW-1:0];
            sy_reg       <= num_reg[48] ^ den_neg_reg;
            degen_p7_reg <= degen_reg;
            ydiv_reg     <= abs2den_reg;
            t2_p7_reg    <= t2_p6_reg;
        end
    end

    logic           ydv_valid;
    logic [YQW-1:0] ydv_q;
    logic [YPW-1:0] ydv_side;

    rtri_div #(
        .NW(YNW),
        .QW(YQW),
        .DW(YDW),
        .PW(YPW)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v7_reg),
        .dividend (ymag_reg),
        .divisor  (ydiv_reg),
        .side     ({t2_p7_reg, sy_reg, degen_p7_reg}),
        .out_valid(ydv_valid),
        .quotient (ydv_q),
        .out_side (ydv_side)
    );

    // back stages
    logic               w1_reg, w2_reg, w3_reg, w4_reg, w5_reg;
    logic signed [47:0] yr1_reg, yr2_reg, yr3_reg;
    logic signed [32:0] t2q1_reg, t2q2_reg, t2q3_reg;
    logic               dg1_reg, dg2_reg, dg3_reg, dg4_reg, dg5_reg;
    logic signed [40:0] pl_reg;
    logic signed [39:0] ph_reg;
    logic signed [63:0] yd_reg;
    logic signed [64:0] xn_reg;
    logic signed [48:0] py4_reg, py5_reg;
    logic [XNW-1:0]     xdvd_reg;
    logic [XDW-1:0]     xdiv_reg;
    logic               sx_reg, big_reg;

    logic signed [47:0] yr_next;
    logic signed [32:0] ydv_t2;
    logic               ydv_sy;
    logic               ydv_dg;
    logic signed [64:0] xn_abs;
    logic [63:0]        xmag;
    logic               big_next;

    assign {ydv_t2, ydv_sy, ydv_dg} = ydv_side;
    assign yr_next  = ydv_sy ? -$signed({1'b0, ydv_q}) : $signed({1'b0, ydv_q});
    assign xn_abs   = xn_reg[64] ? -xn_reg : xn_reg;
    assign xmag     = xn_abs[63:0];
    assign big_next = xmag >= 64'({abs2c_reg, 16'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            w1_reg <= 1'b0;
            w2_reg <= 1'b0;
            w3_reg <= 1'b0;
            w4_reg <= 1'b0;
            w5_reg <= 1'b0;
        end
        else if (en) begin
            w1_reg <= ydv_valid;
            w2_reg <= w1_reg;
            w3_reg <= w2_reg;
            w4_reg <= w3_reg;
            w5_reg <= w4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            yr1_reg  <= yr_next;
            t2q1_reg <= ydv_t2;
            dg1_reg  <= ydv_dg;
            pl_reg   <= $signed({1'b0, yr1_reg[23:0]}) * d_reg;
            ph_reg   <= $signed(yr1_reg[47:24]) * d_reg;
            yr2_reg  <= yr1_reg;
            t2q2_reg <= t2q1_reg;
            dg2_reg  <= dg1_reg;
            yd_reg   <= (64'(ph_reg) <<< 24) + 64'(pl_reg);
            yr3_reg  <= yr2_reg;
            t2q3_reg <= t2q2_reg;
            dg3_reg  <= dg2_reg;
            xn_reg   <= 65'(t2q3_reg) - (65'(yd_reg) <<< 1) + (65'(cm_reg) <<< 1);
            py4_reg  <= 49'(yr3_reg) + $signed({34'b0, n_reg});
            dg4_reg  <= dg3_reg;
            xdvd_reg <= big_next ? '0 : xmag[XNW-1:0];
            xdiv_reg <= abs2c_reg;
            sx_reg   <= xn_reg[64] ^ c_neg_reg;
            big_reg  <= big_next;
            py5_reg  <= py4_reg;
            dg5_reg  <= dg4_reg;
        end
    end

    logic           xdv_valid;
    logic [XQW-1:0] xdv_q;
    logic [XPW-1:0] xdv_side;

    rtri_div #(
        .NW(XNW),
        .QW(XQW),
        .DW(XDW),
        .PW(XPW)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (w5_reg),
        .dividend (xdvd_reg),
        .divisor  (xdiv_reg),
        .side     ({py5_reg, sx_reg, big_reg, dg5_reg}),
        .out_valid(xdv_valid),
        .quotient (xdv_q),
        .out_side (xdv_side)
    );

    logic signed [48:0] xdv_py;
    logic               xdv_sx, xdv_big, xdv_dg;
    rtri_out_t          result_next;
    logic               sat_x, sat_y;
    logic [POS_W-1:0]   px, py;

    assign {xdv_py, xdv_sx, xdv_big, xdv_dg} = xdv_side;

    always_comb
    begin
        sat_x = 1'b0;
        sat_y = 1'b0;
        if (xdv_big) begin
            sat_x = 1'b1;
            px    = xdv_sx ? 16'h8000 : 16'h7fff;
        end
        else if (!xdv_sx) begin
            sat_x = xdv_q[15];
            px    = xdv_q[15] ? 16'h7fff : xdv_q;
        end
        else begin
            sat_x = xdv_q > 16'h8000;
            px    = sat_x ? 16'h8000 : 16'(-xdv_q);
        end
        if (xdv_py > 49'sd32767) begin
            sat_y = 1'b1;
            py    = 16'h7fff;
        end
        else if (xdv_py < -49'sd32768) begin
            sat_y = 1'b1;
            py    = 16'h8000;
        end
        else begin
            py = xdv_py[POS_W-1:0];
        end
        if (xdv_dg) begin
            result_next.pos_x  = '0;
            result_next.pos_y  = '0;
            result_next.status = STATUS_DEGEN;
        end
        else begin
            result_next.pos_x  = $signed(px);
            result_next.pos_y  = $signed(py);
            result_next.status = (sat_x || sat_y) ? STATUS_SAT : STATUS_OK;
        end
    end

    logic      result_valid_reg;
    rtri_out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end
        else if (en) begin
            result_valid_reg <= xdv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== rtl/rtri_checker.sv =====
// Port-level checks of the RSSI trilateration block and their binding.
`timescale 1ns / 1ps
`default_nettype none

module rtri_checker
    import rtri_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 item_stall,
    input wire logic                 result_valid,
    input wire logic                 result_stall,
    input wire rtri_out_t            result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall == (result_valid && result_stall))
        else $error("request stall without result back-pressure");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status == STATUS_OK || result.status == STATUS_DEGEN
                         || result.status == STATUS_SAT)
        else $error("bad status code");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == STATUS_DEGEN |-> result.pos_x == 16'sd0
                                                       && result.pos_y == 16'sd0)
        else $error("degenerate result not zero");

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == STATUS_SAT |->
            result.pos_x == 16'sh7fff || result.pos_x == 16'sh8000
            || result.pos_y == 16'sh7fff || result.pos_y == 16'sh8000)
        else $error("saturated result off the rails");

endmodule

bind rssi_trilateration rtri_checker u_rtri_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_stall  (item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
);

`default_nettype wire

// ===== tb/sv/rssi_trilateration_test.sv =====
// Self-checking testbench for the RSSI trilateration pipeline: scoreboard, drivers and checks.
`timescale 1ns / 1ps

class rtri_scoreboard;
    rtri_pkg::rtri_out_t pending[$];
    longint unsigned     anchor[6];
    int                  errors;
    int                  checked;
    int                  n_degen;
    int                  n_sat;

    function new();
        foreach (anchor[i])
        begin
            anchor[i] = 0;
        end
        errors  = 0;
        checked = 0;
        n_degen = 0;
        n_sat   = 0;
    endfunction

    function void set_anchor(int idx, logic [14:0] val);
        if (idx >= 0 && idx < 6)
        begin
            anchor[idx] = val;
        end
    endfunction

    function longint dist_cm(logic signed [7:0] r, int e);
        int  s;
        real v;
        if (r > 0)
        begin
            s = 0;
        end
        else if (r < -99)
        begin
            s = 99;
        end
        else
        begin
            s = -r;
        end
        v = 100.0 * (10.0 ** ((real'(s) - real'(e)) / real'(e)));
        return longint'($rtoi(v + 0.5));
    endfunction

    function longint clamp16(longint v, ref bit flag);
        if (v > 32767)
        begin
            flag = 1;
            return 32767;
        end
        if (v < -32768)
        begin
            flag = 1;
            return -32768;
        end
        return v;
    endfunction

    function void note_request(rtri_pkg::rtri_in_t req);
        longint m, n, a, b, c, d, d1, d2, d3, den, d12, d13, ab, cd, num, yr, xn, px, py;
        bit     sat;
        rtri_pkg::rtri_out_t res;
        m = anchor[0];
        n = anchor[1];
        a = longint'(anchor[2]) - m;
        b = longint'(anchor[3]) - n;
        c = longint'(anchor[4]) - m;
        d = longint'(anchor[5]) - n;
        d1 = dist_cm(req.rssi_first, 32);
        d2 = dist_cm(req.rssi_second, 37);
        d3 = dist_cm(req.rssi_third, 37);
        den = b * c - d * a;
        sat = 0;
        if (c == 0 || den == 0)
        begin
            res.pos_x  = '0;
            res.pos_y  = '0;
            res.status = rtri_pkg::STATUS_DEGEN;
        end
        else
        begin
            d12 = d1 * d1 - d2 * d2;
            d13 = d1 * d1 - d3 * d3;
            ab  = a * a + b * b;
            cd  = c * c + d * d;
            num = c * (d12 + ab) - a * (d13 + cd);
            yr  = num / (2 * den);
            xn  = d13 + cd - 2 * yr * d + 2 * c * m;
            px  = clamp16(xn / (2 * c), sat);
            py  = clamp16(yr + n, sat);
            res.pos_x  = px[15:0];
            res.pos_y  = py[15:0];
            res.status = sat ? rtri_pkg::STATUS_SAT : rtri_pkg::STATUS_OK;
        end
        pending.push_back(res);
    endfunction

    function void check_result(rtri_pkg::rtri_out_t got);
        rtri_pkg::rtri_out_t exp_res;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result x=%0d y=%0d status=%0d", $time,
                     got.pos_x, got.pos_y, got.status);
            errors++;
            return;
        end
        exp_res = pending.pop_front();
        checked++;
        if (exp_res.status == rtri_pkg::STATUS_DEGEN)
        begin
            n_degen++;
        end
        if (exp_res.status == rtri_pkg::STATUS_SAT)
        begin
            n_sat++;
        end
        if (got.pos_x !== exp_res.pos_x)
        begin
            $display("%0t: pos_x expected %0d actual %0d", $time, exp_res.pos_x, got.pos_x);
            errors++;
        end
        if (got.pos_y !== exp_res.pos_y)
        begin
            $display("%0t: pos_y expected %0d actual %0d", $time, exp_res.pos_y, got.pos_y);
            errors++;
        end
        if (got.status !== exp_res.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status, got.status);
            errors++;
        end
    endfunction
endclass

module rssi_trilateration_test;
    import rtri_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    rtri_in_t  item;
    logic      result_valid;
    logic      result_stall;
    rtri_out_t result;
    logic      cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ANCHOR_W-1:0]  cfg_data;

    rtri_scoreboard sb;
    int  cycles;
    bit  hold_req;
    int  stall_pct;

    rssi_trilateration dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = 400;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                sb.check_result(result);
            end
        end
    end

    task automatic write_anchor(input int idx, input logic [ANCHOR_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= val;
        @(posedge clk);
        sb.set_anchor(idx, val);
    endtask

    task automatic set_anchors(input logic [ANCHOR_W-1:0] x1, y1, x2, y2, x3, y3);
        write_anchor(REG_ANCHOR1_X, x1);
        write_anchor(REG_ANCHOR1_Y, y1);
        write_anchor(REG_ANCHOR2_X, x2);
        write_anchor(REG_ANCHOR2_Y, y2);
        write_anchor(REG_ANCHOR3_X, x3);
        write_anchor(REG_ANCHOR3_Y, y3);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_request(input rtri_in_t req, input int gap);
        item       <= req;
        item_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        sb.note_request(req);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
    endtask

    function automatic logic signed [7:0] rand_rssi();
        if ($urandom_range(9) == 0)
        begin
            return 8'($urandom);
        end
        return 8'(-$signed($urandom_range(99)));
    endfunction

    task automatic random_burst(input int count);
        rtri_in_t req;
        int       burst;
        int       gap;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            req.rssi_first  = rand_rssi();
            req.rssi_second = rand_rssi();
            req.rssi_third  = rand_rssi();
            gap = 0;
            if (burst == 0)
            begin
                burst = $urandom_range(20, 1);
                gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            end
            burst--;
            send_request(req, (i == count - 1) ? 1 : gap);
        end
    endtask

    task automatic directed_set();
        logic signed [7:0] vals[6];
        rtri_in_t req;
        vals = '{8'sd0, -8'sd99, 8'sd127, -8'sd128, -8'sd50, 8'sd1};
        for (int i = 0; i < 6; i++)
        begin
            req.rssi_first  = vals[i];
            req.rssi_second = vals[(i + 1) % 6];
            req.rssi_third  = vals[(i + 3) % 6];
            send_request(req, 0);
        end
        req.rssi_first  = -8'sd99;
        req.rssi_second = 8'sd0;
        req.rssi_third  = 8'sd0;
        send_request(req, 1);
    endtask

    initial
    begin
        sb           = new();
        hold_req     = 0;
        stall_pct    = 0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset anchors: all zero, degenerate
        directed_set();
        drain();
        set_anchors(0, 0, 0, 1000, 1000, 0);
        directed_set();
        drain();
        set_anchors(0, 0, 100, 100, 200, 200);
        directed_set();
        drain();
        set_anchors(32767, 0, 0, 32767, 0, 0);
        directed_set();
        drain();
        set_anchors(32767, 32767, 0, 32767, 32767, 0);
        directed_set();
        drain();
        write_anchor(6, 15'h7fff);
        write_anchor(7, 15'h1234);

        set_anchors(0, 0, 0, 500, 400, 0);
        stall_pct = 20;
        hold_req  = 1;
        random_burst(150);
        drain();

        for (int p = 0; p < 9; p++)
        begin
            if (p % 3 == 0)
            begin
                set_anchors(15'($urandom), 15'($urandom), 15'($urandom),
                            15'($urandom), 15'($urandom), 15'($urandom));
            end
            else
            begin
                set_anchors(15'($urandom_range(2000)), 15'($urandom_range(2000)),
                            15'($urandom_range(2000)), 15'($urandom_range(2000)),
                            15'($urandom_range(2000)), 15'($urandom_range(2000)));
            end
            stall_pct = (p % 4 == 0) ? 0 : $urandom_range(60);
            random_burst(150);
            drain();
        end

        $display("Checked %0d results over 15 anchor settings (%0d degenerate, %0d saturated).",
                 sb.checked, sb.n_degen, sb.n_sat);
        $display("Included out-of-range RSSI, extreme anchors and a long output hold-off.");
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
